// File: rtl/dreq_fifo_dma_channel_core_assert.svh
// Assertion macros for the DREQ FIFO / DMA channel core.
// Define ASSERT_OFF to compile them out.
`ifndef DREQ_FIFO_DMA_CHANNEL_CORE_ASSERT_SVH
`define DREQ_FIFO_DMA_CHANNEL_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define DFDC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define DFDC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DFDC_ASSERT(lbl, clk, rst, prop, msg)
`define DFDC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// File: rtl/dfdc_pkg.sv
package dfdc_pkg;

   // bus function codes
   localparam logic [3:0] FN_CTL_WR  = 4'd0;
   localparam logic [3:0] FN_LEN_WR  = 4'd1;
   localparam logic [3:0] FN_PUSH    = 4'd2;
   localparam logic [3:0] FN_POP     = 4'd3;
   localparam logic [3:0] FN_SRC_WR  = 4'd4;
   localparam logic [3:0] FN_DST_WR  = 4'd5;
   localparam logic [3:0] FN_CNT_WR  = 4'd6;
   localparam logic [3:0] FN_CHAN_WR = 4'd7;
   localparam logic [3:0] FN_OP_WR   = 4'd8;
   localparam logic [3:0] FN_REG_RD  = 4'd9;

   // register read indexes
   localparam logic [2:0] RG_CTL  = 3'd0;
   localparam logic [2:0] RG_LEN  = 3'd1;
   localparam logic [2:0] RG_SRC  = 3'd2;
   localparam logic [2:0] RG_DST  = 3'd3;
   localparam logic [2:0] RG_CNT  = 3'd4;
   localparam logic [2:0] RG_CHAN = 3'd5;
   localparam logic [2:0] RG_OP   = 3'd6;

   // result kinds
   localparam logic [1:0] KIND_ACK   = 2'd0;
   localparam logic [1:0] KIND_MEMWR = 2'd1;
   localparam logic [1:0] KIND_RDATA = 2'd2;

   localparam logic [31:0] FIFO_PORT     = 32'h2000_4012;
   localparam logic [15:0] DREQ_BUSY_BIT = 16'h0004;
   localparam logic [31:0] FOLD_MASK     = 32'h1FFF_FFFF;
   localparam logic [31:0] FOLD_LIMIT    = 32'h4000_0000;
   localparam logic [31:0] DEST_STEP     = 32'd2;

   // words drained per push at most
   localparam int MAX_DRAIN = 8;
   localparam int DRAIN_W   = $clog2(MAX_DRAIN);

   typedef struct packed {
      logic push;
      logic pop;
   } fifo_cmd_type;

   typedef struct packed {
      logic [31:0] dest;
      logic [31:0] count;
      logic [31:0] chan;
      logic [31:0] op;
      logic [31:0] src;
   } chan_regs_type;

   typedef struct packed {
      logic        go;
      logic        next_go;
      logic [31:0] addr;
      logic [31:0] dest_next;
      logic [31:0] count_next;
      logic [31:0] chan_next;
   } step_type;

endpackage

// File: rtl/dfdc_if.sv
interface dfdc_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  func;
   logic [31:0] value;
   logic [2:0]  reg_index;

   modport source (output valid, output func, output value, output reg_index, input ready);
   modport sink (input valid, input func, input value, input reg_index, output ready);
endinterface

interface dfdc_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [31:0] mem_addr;
   logic [15:0] mem_data;
   logic [31:0] read_data;
   logic        last;

   modport source (output valid, output kind, output mem_addr, output mem_data,
                   output read_data, output last, input ready);
   modport sink (input valid, input kind, input mem_addr, input mem_data,
                 input read_data, input last, output ready);
endinterface

// File: rtl/dreq_fifo_dma_channel_core.sv
// DREQ word FIFO with one attached DMA channel.
// req carries bus items (func, value, reg_index); rsp returns results
// (kind, mem_addr, mem_data, read_data, last), last marking the final
// result of an item. Handshakes are valid/ready; a beat moves when both
// are high.
// One item at a time: req.ready is high only while the sequencer is idle,
// so a new item is not accepted until the sequencer is through with the last.
// Register writes, reads, an empty pop and unused codes load the result register
// from the execute state; a pop of a nonempty FIFO goes on through fetch and emit.
// A push runs execute, then fetch and emit for each drained word (up to 8 words)
// or once when nothing drains: the FIFO memory read and the shared step unit that
// forms the address and updates destination, count and channel control.
// A result waits in the output register while rsp.ready is low; the next
// item is still accepted but the sequencer holds until that register frees.
// Reset (synchronous, active high) empties the FIFO, clears the sequencer state
// and the control and channel registers and drops rsp.valid; no clearing pass is needed.
module dreq_fifo_dma_channel_core #(
   parameter int FIFO_DEPTH = 8
) (
   input  logic        clock,
   input  logic        reset,
   dfdc_req_if.sink    req,
   dfdc_rsp_if.source  rsp
);

   `include "dreq_fifo_dma_channel_core_assert.svh"

   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_EXEC  = 2'd1;
   localparam logic [1:0] ST_FETCH = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic [3:0]  func_ff, func_in;
   logic [31:0] value_ff, value_in;
   logic [2:0]  idx_ff, idx_in;
   logic [dfdc_pkg::DRAIN_W-1:0] drain_n_ff, drain_n_in;

   logic [15:0] ctl_reg_ff, ctl_reg_in;
   logic [15:0] len_reg_ff, len_reg_in;
   logic [15:0] words_rem_ff, words_rem_in;
   logic [31:0] src_ff, src_in;
   logic [31:0] dst_ff, dst_in;
   logic [31:0] cnt_ff, cnt_in;
   logic [31:0] chan_ff, chan_in;
   logic [31:0] op_ff, op_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  kind_ff, kind_in;
   logic [31:0] addr_ff, addr_in;
   logic [15:0] mdata_ff, mdata_in;
   logic [31:0] rdata_ff, rdata_in;
   logic        last_ff, last_in;

   logic                   out_load;
   logic                   slot_free;
   logic                   emit_last;
   logic [31:0]            reg_rd;
   dfdc_pkg::fifo_cmd_type fifo_cmd;
   logic [CNT_W-1:0]       fifo_count;
   logic                   fifo_full;
   logic [15:0]            fifo_rd;
   dfdc_pkg::chan_regs_type regs;
   dfdc_pkg::step_type      step;

   dfdc_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .cmd     (fifo_cmd),
      .wr_data (value_ff[15:0]),
      .count   (fifo_count),
      .full    (fifo_full),
      .rd_data (fifo_rd)
   );

   assign regs = '{dest: dst_ff, count: cnt_ff, chan: chan_ff, op: op_ff, src: src_ff};

   dfdc_step_unit u_step (
      .regs (regs),
      .step (step)
   );

   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == ST_IDLE);

   // this word ends the item if the drain cannot go on after it
   assign emit_last = !((drain_n_ff != dfdc_pkg::DRAIN_W'(dfdc_pkg::MAX_DRAIN - 1)) &&
                        (fifo_count > CNT_W'(1)) && step.next_go);

   always_comb begin
      case (idx_ff)
         dfdc_pkg::RG_CTL:  reg_rd = {16'd0, ctl_reg_ff};
         dfdc_pkg::RG_LEN:  reg_rd = {16'd0, len_reg_ff};
         dfdc_pkg::RG_SRC:  reg_rd = src_ff;
         dfdc_pkg::RG_DST:  reg_rd = dst_ff;
         dfdc_pkg::RG_CNT:  reg_rd = cnt_ff;
         dfdc_pkg::RG_CHAN: reg_rd = chan_ff;
         dfdc_pkg::RG_OP:   reg_rd = op_ff;
         default:           reg_rd = '0;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      value_in     = value_ff;
      idx_in       = idx_ff;
      drain_n_in   = drain_n_ff;
      ctl_reg_in   = ctl_reg_ff;
      len_reg_in   = len_reg_ff;
      words_rem_in = words_rem_ff;
      src_in       = src_ff;
      dst_in       = dst_ff;
      cnt_in       = cnt_ff;
      chan_in      = chan_ff;
      op_in        = op_ff;
      fifo_cmd     = '0;
      out_load     = 1'b0;
      kind_in      = dfdc_pkg::KIND_ACK;
      addr_in      = '0;
      mdata_in     = '0;
      rdata_in     = '0;
      last_in      = 1'b1;

      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               func_in    = req.func;
               value_in   = req.value;
               idx_in     = req.reg_index;
               drain_n_in = '0;
               state_in   = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (func_ff)
               dfdc_pkg::FN_PUSH: begin
                  fifo_cmd.push = 1'b1;
                  if (words_rem_ff != '0) begin
                     words_rem_in = words_rem_ff - 16'd1;
                     if (words_rem_ff == 16'd1) begin
                        ctl_reg_in = ctl_reg_ff & ~dfdc_pkg::DREQ_BUSY_BIT;
                     end
                  end
                  state_in = ST_FETCH;
               end
               dfdc_pkg::FN_POP: begin
                  if (fifo_count != '0) begin
                     state_in = ST_FETCH;
                  end else if (slot_free) begin
                     out_load = 1'b1;
                     kind_in  = dfdc_pkg::KIND_RDATA;
                     state_in = ST_IDLE;
                  end
               end
               dfdc_pkg::FN_REG_RD: begin
                  if (slot_free) begin
                     out_load = 1'b1;
                     kind_in  = dfdc_pkg::KIND_RDATA;
                     rdata_in = reg_rd;
                     state_in = ST_IDLE;
                  end
               end
               default: begin
                  if (slot_free) begin
                     out_load = 1'b1;
                     state_in = ST_IDLE;
                     case (func_ff)
                        dfdc_pkg::FN_CTL_WR:  ctl_reg_in = value_ff[15:0];
                        dfdc_pkg::FN_LEN_WR: begin
                           len_reg_in   = value_ff[15:0];
                           words_rem_in = value_ff[15:0];
                        end
                        dfdc_pkg::FN_SRC_WR:  src_in  = value_ff;
                        dfdc_pkg::FN_DST_WR:  dst_in  = value_ff;
                        dfdc_pkg::FN_CNT_WR:  cnt_in  = value_ff;
                        dfdc_pkg::FN_CHAN_WR: chan_in = value_ff;
                        dfdc_pkg::FN_OP_WR:   op_in   = value_ff;
                        default: ;
                     endcase
                  end
               end
            endcase
         end
         ST_FETCH: begin
            // memory read of the FIFO head lands this cycle
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (slot_free) begin
               out_load = 1'b1;
               if (func_ff == dfdc_pkg::FN_POP) begin
                  fifo_cmd.pop = 1'b1;
                  kind_in      = dfdc_pkg::KIND_RDATA;
                  rdata_in     = {16'd0, fifo_rd};
                  state_in     = ST_IDLE;
               end else if ((fifo_count != '0) && step.go) begin
                  fifo_cmd.pop = 1'b1;
                  kind_in      = dfdc_pkg::KIND_MEMWR;
                  addr_in      = step.addr;
                  mdata_in     = fifo_rd;
                  last_in      = emit_last;
                  dst_in       = step.dest_next;
                  cnt_in       = step.count_next;
                  chan_in      = step.chan_next;
                  drain_n_in   = drain_n_ff + 1'b1;
                  state_in     = emit_last ? ST_IDLE : ST_FETCH;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      rsp_valid_in = out_load ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         ctl_reg_ff   <= '0;
         len_reg_ff   <= '0;
         words_rem_ff <= '0;
         src_ff       <= '0;
         dst_ff       <= '0;
         cnt_ff       <= '0;
         chan_ff      <= '0;
         op_ff        <= '0;
         drain_n_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         ctl_reg_ff   <= ctl_reg_in;
         len_reg_ff   <= len_reg_in;
         words_rem_ff <= words_rem_in;
         src_ff       <= src_in;
         dst_ff       <= dst_in;
         cnt_ff       <= cnt_in;
         chan_ff      <= chan_in;
         op_ff        <= op_in;
         drain_n_ff   <= drain_n_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff  <= func_in;
      value_ff <= value_in;
      idx_ff   <= idx_in;
      if (out_load) begin
         kind_ff  <= kind_in;
         addr_ff  <= addr_in;
         mdata_ff <= mdata_in;
         rdata_ff <= rdata_in;
         last_ff  <= last_in;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.kind      = kind_ff;
   assign rsp.mem_addr  = addr_ff;
   assign rsp.mem_data  = mdata_ff;
   assign rsp.read_data = rdata_ff;
   assign rsp.last      = last_ff;

   `DFDC_ASSERT_ALWAYS(a_reset_clears, clock,
      ($past(reset) |-> (state_ff == ST_IDLE && !rsp_valid_ff && fifo_count == '0)),
      "reset did not clear sequencer and FIFO")
   `DFDC_ASSERT(a_wr_needs_go, clock, reset,
      ((out_load && kind_in == dfdc_pkg::KIND_MEMWR) |-> (step.go && fifo_count != '0)),
      "memory write issued without drain conditions")
   `DFDC_ASSERT(a_drain_limit, clock, reset,
      ((out_load && kind_in == dfdc_pkg::KIND_MEMWR &&
        drain_n_ff == dfdc_pkg::DRAIN_W'(dfdc_pkg::MAX_DRAIN - 1)) |-> last_in),
      "drain ran past the per-push limit")
   `DFDC_ASSERT(a_final_word, clock, reset,
      ((out_load && kind_in == dfdc_pkg::KIND_MEMWR && cnt_ff == 32'd1) |=>
       (!chan_ff[0] && chan_ff[1])),
      "final word did not end the channel")
   `DFDC_ASSERT(a_last_idles, clock, reset,
      ((out_load && last_in) |=> (state_ff == ST_IDLE)),
      "sequencer busy after final result")

endmodule

// File: rtl/dfdc_fifo.sv
module dfdc_fifo #(
   parameter int DEPTH = 8,
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dfdc_pkg::fifo_cmd_type cmd,
   input  logic [15:0]           wr_data,
   output logic [CNT_W-1:0]      count,
   output logic                  full,
   output logic [15:0]           rd_data
);

   logic [15:0]      mem_ff [DEPTH];
   logic [15:0]      rd_data_ff;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign do_push = cmd.push && !full;
   assign do_pop  = cmd.pop && (count_ff != '0);

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (do_push) begin
         tail_in = (tail_ff == PTR_W'(DEPTH - 1)) ? '0 : tail_ff + 1'b1;
      end
      if (do_pop) begin
         head_in = (head_ff == PTR_W'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[tail_ff] <= wr_data;
      end
      rd_data_ff <= mem_ff[head_ff];
   end

   assign count   = count_ff;
   assign rd_data = rd_data_ff;

endmodule

// File: rtl/dfdc_step_unit.sv
// One drain step: folded address, register updates and the go checks
// for this word and for the word after it.
module dfdc_step_unit (
   input  dfdc_pkg::chan_regs_type regs,
   output dfdc_pkg::step_type      step
);

   logic last_word;

   assign last_word = (regs.count == 32'd1);

   always_comb begin
      step.addr       = (regs.dest < dfdc_pkg::FOLD_LIMIT) ?
                        (regs.dest & dfdc_pkg::FOLD_MASK) : regs.dest;
      step.dest_next  = regs.dest + dfdc_pkg::DEST_STEP;
      step.count_next = regs.count - 32'd1;
      step.chan_next  = last_word ? ((regs.chan & ~32'd1) | 32'd2) : regs.chan;
      step.go         = regs.op[0] && regs.chan[0] && (regs.count != '0) &&
                        (regs.src == dfdc_pkg::FIFO_PORT);
      step.next_go    = regs.op[0] && step.chan_next[0] && (step.count_next != '0) &&
                        (regs.src == dfdc_pkg::FIFO_PORT);
   end

endmodule

// File: test/dreq_fifo_dma_channel_core_tb.sv
`timescale 1ns / 100ps

module dreq_fifo_dma_channel_core_tb;

   localparam int DEPTH         = 8;
   localparam int RANDOM_ITEMS  = 230;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES   = 300;

   // func codes the block acknowledges and otherwise ignores
   localparam logic [3:0] FN_NOP_FIRST = 4'd10;
   localparam logic [3:0] FN_NOP_LAST  = 4'd15;
   localparam logic [2:0] RG_UNUSED    = 3'd7;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] mem_addr;
      logic [15:0] mem_data;
      logic [31:0] read_data;
      logic        last;
   } rsp_beat_type;

   typedef struct packed {
      logic [3:0]  func;
      logic [31:0] value;
      logic [2:0]  reg_index;
      logic        fixed;
      logic [1:0]  kind;
      logic [31:0] read_data;
   } stim_row_type;

   localparam int NUM_ROWS = 25;

   // rows with fixed set carry their single result typed in
   stim_row_type stim_rows [0:NUM_ROWS-1] = '{
      '{dfdc_pkg::FN_REG_RD, 32'h0, dfdc_pkg::RG_CTL, 1'b1, dfdc_pkg::KIND_RDATA, 32'h0},
      '{dfdc_pkg::FN_REG_RD, 32'h0, dfdc_pkg::RG_SRC, 1'b1, dfdc_pkg::KIND_RDATA, 32'h0},
      '{dfdc_pkg::FN_REG_RD, 32'h0, dfdc_pkg::RG_CNT, 1'b1, dfdc_pkg::KIND_RDATA, 32'h0},
      '{dfdc_pkg::FN_REG_RD, 32'h0, dfdc_pkg::RG_CHAN, 1'b1, dfdc_pkg::KIND_RDATA, 32'h0},
      '{dfdc_pkg::FN_REG_RD, 32'hFFFF_FFFF, RG_UNUSED, 1'b1, dfdc_pkg::KIND_RDATA, 32'h0},
      '{dfdc_pkg::FN_POP, 32'h0, dfdc_pkg::RG_CTL, 1'b1, dfdc_pkg::KIND_RDATA, 32'h0},
      '{FN_NOP_LAST, 32'hFFFF_FFFF, RG_UNUSED, 1'b1, dfdc_pkg::KIND_ACK, 32'h0},
      '{dfdc_pkg::FN_CTL_WR, 32'hFFFF_FFFF, dfdc_pkg::RG_CTL, 1'b0, dfdc_pkg::KIND_ACK, 32'h0},
      '{dfdc_pkg::FN_LEN_WR, 32'hFFFF_0002, dfdc_pkg::RG_CTL, 1'b0, dfdc_pkg::KIND_ACK, 32'h0},
      '{dfdc_pkg::FN_PUSH, 32'hFFFF_FFFF, dfdc_pkg::RG_CTL, 1'b0, dfdc_pkg::KIND_ACK, 32'h0},
      '{dfdc_pkg::FN_PUSH, 32'h0000_0000, dfdc_pkg::RG_CTL, 1'b0, dfdc_pkg::KIND_ACK, 32'h0},
      '{dfdc_pkg::FN_PUSH, 32'h0000_A5A5, dfdc_pkg::RG_CTL, 1'b0, dfdc_pkg::KIND_ACK, 32'h0},
      '{dfdc_pkg::FN_REG_RD, 32'h0, dfdc_pkg::RG_CTL, 1'b0, dfdc_pkg::KIND_ACK, 32'h0},
      '{dfdc_pkg::FN_REG_RD, 32'h0, dfdc_pkg::RG_LEN, 1'b0, dfdc_pkg::KIND_ACK, 32'h0},
      '{dfdc_pkg::FN_POP, 32'h0, dfdc_pkg::RG_CTL, 1'b0, dfdc_pkg::KIND_ACK, 32'h0},
      '{dfdc_pkg::FN_SRC_WR, dfdc_pkg::FIFO_PORT, dfdc_pkg::RG_CTL, 1'b0,
        dfdc_pkg::KIND_ACK, 32'h0},
      '{dfdc_pkg::FN_DST_WR, 32'h3FFF_FFFC, dfdc_pkg::RG_CTL, 1'b0, dfdc_pkg::KIND_ACK, 32'h0},
      '{dfdc_pkg::FN_CNT_WR, 32'h0000_0003, dfdc_pkg::RG_CTL, 1'b0, dfdc_pkg::KIND_ACK, 32'h0},
      '{dfdc_pkg::FN_OP_WR, 32'hFFFF_FFFF, dfdc_pkg::RG_CTL, 1'b0, dfdc_pkg::KIND_ACK, 32'h0},
      '{dfdc_pkg::FN_CHAN_WR, 32'hFFFF_FFFF, dfdc_pkg::RG_CTL, 1'b0, dfdc_pkg::KIND_ACK, 32'h0},
      '{dfdc_pkg::FN_PUSH, 32'hFFFF_1234, dfdc_pkg::RG_CTL, 1'b0, dfdc_pkg::KIND_ACK, 32'h0},
      '{dfdc_pkg::FN_REG_RD, 32'h0, dfdc_pkg::RG_CHAN, 1'b0, dfdc_pkg::KIND_ACK, 32'h0},
      '{dfdc_pkg::FN_REG_RD, 32'h0, dfdc_pkg::RG_DST, 1'b0, dfdc_pkg::KIND_ACK, 32'h0},
      '{dfdc_pkg::FN_REG_RD, 32'h0, dfdc_pkg::RG_OP, 1'b0, dfdc_pkg::KIND_ACK, 32'h0},
      '{FN_NOP_FIRST, 32'h0, RG_UNUSED, 1'b1, dfdc_pkg::KIND_ACK, 32'h0}
   };

   logic clock;
   logic reset;

   dfdc_req_if req_bus ();
   dfdc_rsp_if rsp_bus ();

   dreq_fifo_dma_channel_core #(
      .FIFO_DEPTH(DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req  (req_bus),
      .rsp  (rsp_bus)
   );

   // channel state as the bus sees it
   logic [15:0] queued_words[$];
   logic [15:0] ctl_reg;
   logic [15:0] len_reg;
   logic [15:0] words_left;
   logic [31:0] src_addr;
   logic [31:0] dst_addr;
   logic [31:0] xfer_count;
   logic [31:0] chan_ctl;
   logic [31:0] op_ctl;

   rsp_beat_type due_results[$];
   int error_count = 0;
   int sent_items = 0;
   int cycle_count = 0;
   bit send_quiet = 0;
   bit recv_quiet = 0;
   int hold_req_id = 0;
   int hold_seen_id = 0;
   int hold_left = 0;
   int recv_stall_left = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still due",
                  cycle_count, due_results.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic flag_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
      error_count++;
   endtask

   task automatic compute_bus_results(input logic [3:0] fn, input logic [31:0] val,
                                      input logic [2:0] idx);
      rsp_beat_type beats[$];
      rsp_beat_type b;
      logic [31:0] addr;
      logic [31:0] rd;
      logic [15:0] w;
      case (fn)
         dfdc_pkg::FN_CTL_WR: ctl_reg = val[15:0];
         dfdc_pkg::FN_LEN_WR: begin
            len_reg = val[15:0];
            words_left = val[15:0];
         end
         dfdc_pkg::FN_PUSH: begin
            // a full queue drops the word but countdown and drain still run
            if (queued_words.size() < DEPTH)
               queued_words.push_back(val[15:0]);
            if (words_left != 16'h0) begin
               words_left = words_left - 16'h1;
               if (words_left == 16'h0)
                  ctl_reg = ctl_reg & ~dfdc_pkg::DREQ_BUSY_BIT;
            end
            while (beats.size() < dfdc_pkg::MAX_DRAIN && queued_words.size() > 0
                   && op_ctl[0] && chan_ctl[0] && xfer_count != 32'h0
                   && src_addr == dfdc_pkg::FIFO_PORT) begin
               addr = (dst_addr < dfdc_pkg::FOLD_LIMIT) ? (dst_addr & dfdc_pkg::FOLD_MASK)
                                                        : dst_addr;
               w = queued_words.pop_front();
               b = '{dfdc_pkg::KIND_MEMWR, addr, w, 32'h0, 1'b0};
               beats.push_back(b);
               dst_addr = dst_addr + dfdc_pkg::DEST_STEP;
               if (xfer_count == 32'h1)
                  chan_ctl = {chan_ctl[31:2], 2'b10};
               xfer_count = xfer_count - 32'h1;
            end
         end
         dfdc_pkg::FN_POP: begin
            rd = 32'h0;
            if (queued_words.size() > 0)
               rd = {16'h0, queued_words.pop_front()};
            b = '{dfdc_pkg::KIND_RDATA, 32'h0, 16'h0, rd, 1'b0};
            beats.push_back(b);
         end
         dfdc_pkg::FN_SRC_WR:  src_addr = val;
         dfdc_pkg::FN_DST_WR:  dst_addr = val;
         dfdc_pkg::FN_CNT_WR:  xfer_count = val;
         dfdc_pkg::FN_CHAN_WR: chan_ctl = val;
         dfdc_pkg::FN_OP_WR:   op_ctl = val;
         dfdc_pkg::FN_REG_RD: begin
            case (idx)
               dfdc_pkg::RG_CTL:  rd = {16'h0, ctl_reg};
               dfdc_pkg::RG_LEN:  rd = {16'h0, len_reg};
               dfdc_pkg::RG_SRC:  rd = src_addr;
               dfdc_pkg::RG_DST:  rd = dst_addr;
               dfdc_pkg::RG_CNT:  rd = xfer_count;
               dfdc_pkg::RG_CHAN: rd = chan_ctl;
               dfdc_pkg::RG_OP:   rd = op_ctl;
               default: rd = 32'h0;
            endcase
            b = '{dfdc_pkg::KIND_RDATA, 32'h0, 16'h0, rd, 1'b0};
            beats.push_back(b);
         end
         default: ;
      endcase
      if (beats.size() == 0) begin
         b = '{dfdc_pkg::KIND_ACK, 32'h0, 16'h0, 32'h0, 1'b0};
         beats.push_back(b);
      end
      beats[beats.size()-1].last = 1'b1;
      foreach (beats[i])
         due_results.push_back(beats[i]);
   endtask

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 92)
         return $urandom_range(1, 3);
      else
         return $urandom_range(10, 40);
   endfunction

   // called at a rising edge; returns at the edge the beat was accepted
   task automatic send_item(input logic [3:0] fn, input logic [31:0] val,
                            input logic [2:0] idx);
      int gap;
      gap = send_quiet ? 0 : gap_len();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.func      <= fn;
      req_bus.value     <= val;
      req_bus.reg_index <= idx;
      forever begin
         @(posedge clock);
         if (req_bus.ready)
            break;
      end
      sent_items++;
      compute_bus_results(fn, val, idx);
   endtask

   function automatic logic [31:0] pick_dest();
      case ($urandom_range(0, 4))
         0: return {2'b00, 30'($urandom)} & 32'hFFFF_FFFE;
         1: return 32'h3FFF_FFF0 + 2 * $urandom_range(0, 8);
         2: return 32'hFFFF_FFF0 + 2 * $urandom_range(0, 7);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_count();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6)
         return $urandom_range(1, 10);
      else if (r < 8)
         return 32'h0;
      else if (r < 9)
         return $urandom;
      else
         return 32'hFFFF_FFFF;
   endfunction

   function automatic logic [2:0] any_index();
      return 3'($urandom_range(0, 7));
   endfunction

   task automatic send_side_item();
      logic [31:0] v;
      v = $urandom;
      case ($urandom_range(0, 3))
         0: send_item(dfdc_pkg::FN_POP, v, any_index());
         1: send_item(dfdc_pkg::FN_REG_RD, v, any_index());
         2: begin
            v[15:0] = 16'($urandom_range(0, 4));
            send_item(dfdc_pkg::FN_LEN_WR, v, any_index());
         end
         default: send_item(dfdc_pkg::FN_CTL_WR, v, any_index());
      endcase
   endtask

   // full channel setup, then pushes with a few other accesses mixed in
   task automatic run_drain_burst();
      logic [31:0] v;
      int pushes;
      v = ($urandom_range(0, 9) == 0) ? ($urandom | 32'h1) ^ dfdc_pkg::FIFO_PORT
                                      : dfdc_pkg::FIFO_PORT;
      send_item(dfdc_pkg::FN_SRC_WR, v, any_index());
      send_item(dfdc_pkg::FN_DST_WR, pick_dest(), any_index());
      send_item(dfdc_pkg::FN_CNT_WR, pick_count(), any_index());
      v = $urandom;
      v[0] = ($urandom_range(0, 9) != 0);
      send_item(dfdc_pkg::FN_OP_WR, v, any_index());
      v = $urandom;
      v[0] = ($urandom_range(0, 9) != 0);
      send_item(dfdc_pkg::FN_CHAN_WR, v, any_index());
      pushes = $urandom_range(1, 12);
      repeat (pushes) begin
         if ($urandom_range(0, 4) == 0)
            send_side_item();
         send_item(dfdc_pkg::FN_PUSH, $urandom, any_index());
      end
   endtask

   // queue up to full or past it with the channel off, then let one push drain it as far as the count allows
   task automatic run_fill_release();
      logic [31:0] v;
      v = $urandom;
      v[0] = 1'b0;
      send_item(dfdc_pkg::FN_CHAN_WR, v, any_index());
      repeat ($urandom_range(8, 10))
         send_item(dfdc_pkg::FN_PUSH, $urandom, any_index());
      send_item(dfdc_pkg::FN_SRC_WR, dfdc_pkg::FIFO_PORT, any_index());
      send_item(dfdc_pkg::FN_DST_WR, pick_dest(), any_index());
      send_item(dfdc_pkg::FN_CNT_WR, $urandom_range(1, 20), any_index());
      send_item(dfdc_pkg::FN_OP_WR, $urandom | 32'h1, any_index());
      send_item(dfdc_pkg::FN_CHAN_WR, $urandom | 32'h1, any_index());
      send_item(dfdc_pkg::FN_PUSH, $urandom, any_index());
   endtask

   task automatic run_length_countdown();
      logic [31:0] v;
      send_item(dfdc_pkg::FN_CTL_WR, $urandom, any_index());
      v = $urandom;
      if ($urandom_range(0, 9) != 0)
         v[15:0] = 16'($urandom_range(0, 5));
      send_item(dfdc_pkg::FN_LEN_WR, v, any_index());
      repeat ($urandom_range(1, 6))
         send_item(dfdc_pkg::FN_PUSH, $urandom, any_index());
      send_item(dfdc_pkg::FN_REG_RD, $urandom, dfdc_pkg::RG_CTL);
      send_item(dfdc_pkg::FN_REG_RD, $urandom, dfdc_pkg::RG_LEN);
   endtask

   task automatic run_noise();
      repeat ($urandom_range(3, 8))
         send_item(4'($urandom_range(0, 15)), $urandom, any_index());
   endtask

   task automatic check_beat();
      rsp_beat_type want;
      if (due_results.size() == 0) begin
         flag_mismatch("unexpected beat kind", {30'h0, rsp_bus.kind}, 32'h0);
      end else begin
         want = due_results.pop_front();
         if (rsp_bus.kind !== want.kind)
            flag_mismatch("kind", {30'h0, rsp_bus.kind}, {30'h0, want.kind});
         if (rsp_bus.mem_addr !== want.mem_addr)
            flag_mismatch("mem_addr", rsp_bus.mem_addr, want.mem_addr);
         if (rsp_bus.mem_data !== want.mem_data)
            flag_mismatch("mem_data", {16'h0, rsp_bus.mem_data}, {16'h0, want.mem_data});
         if (rsp_bus.read_data !== want.read_data)
            flag_mismatch("read_data", rsp_bus.read_data, want.read_data);
         if (rsp_bus.last !== want.last)
            flag_mismatch("last", {31'h0, rsp_bus.last}, {31'h0, want.last});
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready)
            check_beat();
         if ($urandom_range(0, 299) == 0)
            recv_quiet = !recv_quiet;
         if (hold_req_id != hold_seen_id) begin
            hold_seen_id = hold_req_id;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (recv_stall_left > 0) begin
            recv_stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (!recv_quiet)
               recv_stall_left = gap_len();
         end
      end
   end

   initial begin
      stim_row_type row;
      rsp_beat_type typed;
      bit hold_done;
      int pick;
      hold_done = 0;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.func = dfdc_pkg::FN_CTL_WR;
      req_bus.value = 32'h0;
      req_bus.reg_index = dfdc_pkg::RG_CTL;

      queued_words.delete();
      ctl_reg = 16'h0;
      len_reg = 16'h0;
      words_left = 16'h0;
      src_addr = 32'h0;
      dst_addr = 32'h0;
      xfer_count = 32'h0;
      chan_ctl = 32'h0;
      op_ctl = 32'h0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NUM_ROWS; i++) begin
         row = stim_rows[i];
         send_item(row.func, row.value, row.reg_index);
         if (row.fixed) begin
            typed = '{row.kind, 32'h0, 16'h0, row.read_data, 1'b1};
            due_results[due_results.size()-1] = typed;
         end
      end

      while (sent_items < NUM_ROWS + RANDOM_ITEMS) begin
         send_quiet = ($urandom_range(0, 3) == 0);
         if (!hold_done && sent_items > NUM_ROWS + 100) begin
            // long receiver hold while items keep coming
            hold_req_id <= hold_req_id + 1;
            hold_done = 1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 55)
            run_drain_burst();
         else if (pick < 70)
            run_fill_release();
         else if (pick < 85)
            run_length_countdown();
         else
            run_noise();
      end
      req_bus.valid <= 1'b0;

      while (due_results.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (error_count == 0 && due_results.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl
rtl/dfdc_pkg.sv
rtl/dfdc_if.sv
rtl/dfdc_fifo.sv
rtl/dfdc_step_unit.sv
rtl/dreq_fifo_dma_channel_core.sv
test/dreq_fifo_dma_channel_core_tb.sv
